### rtl/core/adam_optimizer_update_defines.svh
// ----------------------------------------------------------------------------
// Adam optimizer update - assertion macros
// Concurrent checks clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ADAM_OPTIMIZER_UPDATE_DEFINES_SVH
`define ADAM_OPTIMIZER_UPDATE_DEFINES_SVH
`ifndef ASSERT_OFF
`define AOU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define AOU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define AOU_ASSERT_IMP(lbl, ante, cons)
`define AOU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/core/adam_opt_pkg.sv
// ----------------------------------------------------------------------------
// Adam optimizer update - package
// Field widths, register map and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package adam_opt_pkg;

  localparam int IDX_W  = 16;
  localparam int DATA_W = 32;
  localparam int BETA_W = 16;
  localparam int LR_W   = 24;
  localparam int ADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam int ELEMENTS_DEF = 65536;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_BETA_FIRST    = 2'd0;
  localparam logic [1:0] REG_BETA_SECOND   = 2'd1;
  localparam logic [1:0] REG_LEARNING_RATE = 2'd2;

  localparam logic [BETA_W-1:0] BETA_FIRST_RST  = 16'd58982;
  localparam logic [BETA_W-1:0] BETA_SECOND_RST = 16'd65470;
  localparam logic [LR_W-1:0]   LR_RST          = 24'd16777;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [27:0] EPS_Q   = 28'd1678;   // 0.0001 in Q.24
  localparam logic [31:0] DATA_MAX = 32'h7FFF_FFFF;

endpackage

`default_nettype wire

### rtl/core/adam_opt_in_if.sv
// ----------------------------------------------------------------------------
// Adam optimizer update - gradient channel
// valid/ready channel carrying one gradient element.
// ----------------------------------------------------------------------------
`default_nettype none

interface adam_opt_in_if;
  logic                                     valid;
  logic                                     ready;
  logic        [adam_opt_pkg::IDX_W-1:0]    element_index;
  logic signed [adam_opt_pkg::DATA_W-1:0]   gradient;
  logic                                     last_of_pass;

  modport source (output valid, element_index, gradient, last_of_pass, input ready);
  modport sink   (input valid, element_index, gradient, last_of_pass, output ready);
endinterface

`default_nettype wire

### rtl/core/adam_opt_out_if.sv
// ----------------------------------------------------------------------------
// Adam optimizer update - step channel
// valid/ready channel carrying one computed step.
// ----------------------------------------------------------------------------
`default_nettype none

interface adam_opt_out_if;
  logic                                     valid;
  logic                                     ready;
  logic        [adam_opt_pkg::IDX_W-1:0]    element_index_out;
  logic signed [adam_opt_pkg::DATA_W-1:0]   step_value;
  logic                                     last_out;

  modport source (output valid, element_index_out, step_value, last_out, input ready);
  modport sink   (input valid, element_index_out, step_value, last_out, output ready);
endinterface

`default_nettype wire

### rtl/core/adam_optimizer_update.sv
// ----------------------------------------------------------------------------
// Adam optimizer update - top level
// Takes one gradient element per cycle while not stalled by output
// back-pressure, an index hazard or the clearing pass, updates its first and
// second moment in two on-chip stores and returns the bias-corrected step
// lr * mhat / (sqrt(vhat) + 0.0001) in signed Q8.24, saturated. An item whose
// slot (element index modulo ELEMENTS) matches one of the two items in the
// moment read-modify-write stages is held until they have written back. Both
// bias divisions and the step division are 2-bit-per-stage pipelined dividers
// and the square root a 2-bit-per-stage pipeline. After reset a clearing pass
// over all ELEMENTS slots zeroes the moment stores; no item is accepted
// meanwhile. The output register has one skid entry behind it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "adam_optimizer_update_defines.svh"

module adam_optimizer_update #(
  parameter int ELEMENTS = adam_opt_pkg::ELEMENTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  adam_opt_in_if.sink                              grad,
  adam_opt_out_if.source                           step,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [adam_opt_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [adam_opt_pkg::PDATA_W-1:0]    pwdata,
  output logic      [adam_opt_pkg::PDATA_W-1:0]    prdata,
  output logic                                     pready
);

  localparam int AW    = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int DV_N  = 16;               // divider stages, 2 quotient bits each
  localparam int SQ_N  = 14;               // square root stages, 2 root bits each
  localparam int POS_C = DV_N + 1;
  localparam int POS_E = POS_C + SQ_N + 1;
  localparam int POS_F = POS_E + 1;
  localparam int POS_Z = POS_F + DV_N + 1;

  localparam logic signed [34:0] SAT_HI = 35'sd2147483647;
  localparam logic signed [34:0] SAT_LO = -35'sd2147483648;

  typedef struct packed {
    logic [adam_opt_pkg::IDX_W-1:0] idx;
    logic                           last;
    logic                           neg;
  } tag_t;

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic logic [15:0] mod_steps(input logic [15:0] r, input int hi,
                                            input int lo);
    logic [40:0] sub;
    logic [15:0] x;
    x = r;
    for (int k = 15; k >= 0; k--) begin
      if (k <= hi && k >= lo) begin
        sub = 41'(ELEMENTS) << k;
        if ({25'b0, x} >= sub) x = x - sub[15:0];
      end
    end
    return x;
  endfunction

  function automatic logic signed [31:0] sat35(input logic signed [34:0] x);
    if (x > SAT_HI) return 32'sh7FFF_FFFF;
    else if (x < SAT_LO) return 32'sh8000_0000;
    else return x[31:0];
  endfunction

  function automatic logic [31:0] mag_cap(input logic neg);
    return adam_opt_pkg::DATA_MAX + 32'(neg);
  endfunction

  // two restoring-division steps: {remainder, quotient/dividend shift}
  function automatic logic [59:0] div_step(input logic [27:0] r, input logic [31:0] qx,
                                           input logic [27:0] d);
    logic [28:0] r2;
    logic [27:0] rr;
    logic [31:0] q;
    rr = r;
    q  = qx;
    for (int i = 0; i < 2; i++) begin
      r2 = {rr, q[31]};
      q  = {q[30:0], 1'b0};
      if (r2 >= {1'b0, d}) begin
        r2   = r2 - {1'b0, d};
        q[0] = 1'b1;
      end
      rr = r2[27:0];
    end
    return {rr, q};
  endfunction

  // two restoring square-root steps: {remainder, root, radicand shift}
  function automatic logic [113:0] sqrt_step(input logic [29:0] rem, input logic [27:0] root,
                                             input logic [55:0] xs);
    logic [31:0] r32;
    logic [31:0] trial;
    logic [29:0] rm;
    logic [27:0] rt;
    logic [55:0] x;
    rm = rem;
    rt = root;
    x  = xs;
    for (int i = 0; i < 2; i++) begin
      r32   = {rm, x[55:54]};
      trial = {2'b0, rt, 2'b01};
      x     = {x[53:0], 2'b00};
      rt    = {rt[26:0], 1'b0};
      if (r32 >= trial) begin
        r32   = r32 - trial;
        rt[0] = 1'b1;
      end
      rm = r32[29:0];
    end
    return {rm, rt, x};
  endfunction

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [adam_opt_pkg::BETA_W-1:0] beta1, beta2;
  logic [adam_opt_pkg::LR_W-1:0]   lr;
  logic [16:0]                     pow1, pow2;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta1 <= adam_opt_pkg::BETA_FIRST_RST;
      beta2 <= adam_opt_pkg::BETA_SECOND_RST;
      lr    <= adam_opt_pkg::LR_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        adam_opt_pkg::REG_BETA_FIRST:    beta1 <= pwdata[15:0];
        adam_opt_pkg::REG_BETA_SECOND:   beta2 <= pwdata[15:0];
        adam_opt_pkg::REG_LEARNING_RATE: lr    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      adam_opt_pkg::REG_BETA_FIRST:    prdata = 32'(beta1);
      adam_opt_pkg::REG_BETA_SECOND:   prdata = 32'(beta2);
      adam_opt_pkg::REG_LEARNING_RATE: prdata = 32'(lr);
      default:                         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  logic          clearing;
  logic [AW-1:0] clr_cnt;
  logic          out_v, skid_v;
  logic          move, fen, hazard, grad_rdy;

  logic v0, v1, v2, v3, v4, v5;
  logic [15:0] idx0, idx1, idx2, idx3, idx4, idx5;
  logic signed [31:0] g0, g1, g2, g3, g4;
  logic last0, last1, last2, last3, last4, last5;
  logic [15:0]   r1;
  logic [63:0]   sqp1;
  logic [31:0]   sq2, sq3, sq4;
  logic [AW-1:0] slot2, slot3, slot4;
  logic signed [31:0] rm3, rv3;
  logic signed [49:0] t1_4, t2_4;
  logic signed [31:0] m5, vv5;

  logic vb [0:POS_Z];
  tag_t tg [0:POS_Z];

  assign move     = !skid_v;
  assign hazard   = v2 && ((v3 && slot3 == slot2) || (v4 && slot4 == slot2));
  assign fen      = move && !hazard;
  assign grad_rdy = fen && !clearing;
  assign grad.ready = grad_rdy;

  // --------------------------------------------------------------------------
  // front: index wrap, gradient square
  // --------------------------------------------------------------------------
  logic [31:0] g0u, mag0;
  logic [15:0] r1_next, slot2_next;
  logic [31:0] sq2_next;

  always_comb begin
    g0u        = g0;
    mag0       = g0[31] ? (~g0u + 32'd1) : g0u;
    r1_next    = mod_steps(idx0, 15, 8);
    slot2_next = mod_steps(r1, 7, 0);
    sq2_next   = (sqp1[63:24] > 40'(adam_opt_pkg::DATA_MAX)) ? adam_opt_pkg::DATA_MAX
                                                              : sqp1[55:24];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (fen) begin
      v0 <= grad.valid && grad_rdy;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      idx0  <= grad.element_index;
      g0    <= grad.gradient;
      last0 <= grad.last_of_pass;
      idx1  <= idx0;
      g1    <= g0;
      last1 <= last0;
      r1    <= r1_next;
      sqp1  <= 64'(mag0) * 64'(mag0);
      idx2  <= idx1;
      g2    <= g1;
      last2 <= last1;
      slot2 <= AW'(slot2_next);
      sq2   <= sq2_next;
    end
  end

  // --------------------------------------------------------------------------
  // moment stores and read-modify-write
  // --------------------------------------------------------------------------
  logic signed [31:0] m_mem [0:ELEMENTS-1];
  logic signed [31:0] v_mem [0:ELEMENTS-1];

  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic signed [31:0] mem_wm, mem_wv;
  logic signed [32:0] diff_m, diff_v;
  logic signed [16:0] bm1, bm2;
  logic signed [49:0] t1_next, t2_next;
  logic signed [31:0] mn, vn, vn_s;

  always_comb begin
    diff_m  = 33'(rm3) - 33'(g3);
    diff_v  = 33'(rv3) - 33'($signed({1'b0, sq3}));
    bm1     = $signed({1'b0, beta1});
    bm2     = $signed({1'b0, beta2});
    t1_next = 50'(bm1) * 50'(diff_m);
    t2_next = 50'(bm2) * 50'(diff_v);
    // b*m + (1-b)*g == g + b*(m-g), floor division by 2^16
    mn      = sat35(35'(g4) + 35'(t1_4 >>> 16));
    vn_s    = sat35(35'($signed({1'b0, sq4})) + 35'(t2_4 >>> 16));
    vn      = vn_s[31] ? 32'sd0 : vn_s;
    if (clearing) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt;
      mem_wm = '0;
      mem_wv = '0;
    end else begin
      mem_we = move && v4;
      mem_wa = slot4;
      mem_wm = mn;
      mem_wv = vn;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      m_mem[mem_wa] <= mem_wm;
      v_mem[mem_wa] <= mem_wv;
    end
    if (move) begin
      rm3 <= m_mem[slot2];
      rv3 <= v_mem[slot2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + AW'(1);
      if (clr_cnt == AW'(ELEMENTS - 1)) clearing <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // bias correction powers
  // --------------------------------------------------------------------------
  logic [16:0] p1_next, p2_next, den1, den2;
  logic [31:0] m5u, mabs5, vv5u;

  always_comb begin
    p1_next = 17'((34'(pow1) * 34'(beta1)) >> 16);
    p2_next = 17'((34'(pow2) * 34'(beta2)) >> 16);
    den1    = adam_opt_pkg::ONE_Q16 - p1_next;
    den2    = adam_opt_pkg::ONE_Q16 - p2_next;
    m5u     = m5;
    vv5u    = vv5;
    mabs5   = m5[31] ? (~m5u + 32'd1) : m5u;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pow1 <= adam_opt_pkg::ONE_Q16;
      pow2 <= adam_opt_pkg::ONE_Q16;
    end else if (move && v5 && last5) begin
      pow1 <= p1_next;
      pow2 <= p2_next;
    end
  end

  // --------------------------------------------------------------------------
  // back end: bias dividers, square root, step divider
  // --------------------------------------------------------------------------
  logic [27:0] d1r [0:DV_N];
  logic [31:0] d1q [0:DV_N];
  logic [27:0] d1d [0:DV_N];
  logic        d1o [0:DV_N];
  logic [27:0] d2r [0:DV_N];
  logic [31:0] d2q [0:DV_N];
  logic [27:0] d2d [0:DV_N];
  logic        d2o [0:DV_N];
  logic [29:0] sqr [0:SQ_N];
  logic [27:0] sqt [0:SQ_N];
  logic [55:0] sqx [0:SQ_N];
  logic [31:0] sqm [0:SQ_N];
  logic [55:0] prod_e;
  logic [27:0] den_e;
  logic [27:0] sdr [0:DV_N];
  logic [31:0] sdq [0:DV_N];
  logic [27:0] sdd [0:DV_N];
  logic        sdo [0:DV_N];
  logic [31:0] sz;

  logic [31:0] cap_c, mhat_mag, vhat_sat, cap_z, magz;
  logic [30:0] vhat_lo;

  always_comb begin
    cap_c    = mag_cap(tg[DV_N].neg);
    mhat_mag = (d1o[DV_N] || d1q[DV_N] > cap_c) ? cap_c : d1q[DV_N];
    vhat_sat = (d2o[DV_N] || d2q[DV_N] > adam_opt_pkg::DATA_MAX) ? adam_opt_pkg::DATA_MAX
                                                                 : d2q[DV_N];
    vhat_lo  = vhat_sat[30:0];
    cap_z    = mag_cap(tg[POS_Z-1].neg);
    magz     = (sdo[DV_N] || sdq[DV_N] > cap_z) ? cap_z : sdq[DV_N];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      for (int k = 0; k <= POS_Z; k++) vb[k] <= 1'b0;
    end else if (move) begin
      v3 <= v2 && !hazard;
      v4 <= v3;
      v5 <= v4;
      vb[0] <= v5;
      for (int k = 1; k <= POS_Z; k++) vb[k] <= vb[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      idx3  <= idx2;
      g3    <= g2;
      last3 <= last2;
      slot3 <= slot2;
      sq3   <= sq2;
      idx4  <= idx3;
      g4    <= g3;
      last4 <= last3;
      slot4 <= slot3;
      sq4   <= sq3;
      t1_4  <= t1_next;
      t2_4  <= t2_next;
      idx5  <= idx4;
      last5 <= last4;
      m5    <= mn;
      vv5   <= vn;

      tg[0] <= '{idx: idx5, last: last5, neg: m5[31]};
      for (int k = 1; k <= POS_Z; k++) tg[k] <= tg[k-1];

      // bias division: |m| * 2^16 / (1 - beta^t), v * 2^16 / (1 - beta^t)
      d1r[0] <= 28'(mabs5[31:16]);
      d1q[0] <= {mabs5[15:0], 16'b0};
      d1d[0] <= 28'(den1);
      d1o[0] <= {1'b0, mabs5[31:16]} >= den1;
      d2r[0] <= 28'(vv5u[31:16]);
      d2q[0] <= {vv5u[15:0], 16'b0};
      d2d[0] <= 28'(den2);
      d2o[0] <= {1'b0, vv5u[31:16]} >= den2;
      for (int k = 1; k <= DV_N; k++) begin
        {d1r[k], d1q[k]} <= div_step(d1r[k-1], d1q[k-1], d1d[k-1]);
        d1d[k] <= d1d[k-1];
        d1o[k] <= d1o[k-1];
        {d2r[k], d2q[k]} <= div_step(d2r[k-1], d2q[k-1], d2d[k-1]);
        d2d[k] <= d2d[k-1];
        d2o[k] <= d2o[k-1];
      end

      // square root of vhat in Q.24
      sqr[0] <= '0;
      sqt[0] <= '0;
      sqx[0] <= {1'b0, vhat_lo, 24'b0};
      sqm[0] <= mhat_mag;
      for (int k = 1; k <= SQ_N; k++) begin
        {sqr[k], sqt[k], sqx[k]} <= sqrt_step(sqr[k-1], sqt[k-1], sqx[k-1]);
        sqm[k] <= sqm[k-1];
      end

      prod_e <= 56'(lr) * 56'(sqm[SQ_N]);
      den_e  <= sqt[SQ_N] + adam_opt_pkg::EPS_Q;

      // step division: lr * |mhat| / (root + eps)
      sdr[0] <= 28'(prod_e[55:32]);
      sdq[0] <= prod_e[31:0];
      sdd[0] <= den_e;
      sdo[0] <= 28'(prod_e[55:32]) >= den_e;
      for (int k = 1; k <= DV_N; k++) begin
        {sdr[k], sdq[k]} <= div_step(sdr[k-1], sdq[k-1], sdd[k-1]);
        sdd[k] <= sdd[k-1];
        sdo[k] <= sdo[k-1];
      end

      sz <= tg[POS_Z-1].neg ? (~magz + 32'd1) : magz;
    end
  end

  // --------------------------------------------------------------------------
  // output register with one skid entry
  // --------------------------------------------------------------------------
  logic [15:0] out_idx, skid_idx;
  logic [31:0] out_val, skid_val;
  logic        out_last, skid_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || step.ready) begin
      out_v  <= skid_v || vb[POS_Z];
      skid_v <= 1'b0;
    end else if (vb[POS_Z] && move) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || step.ready) begin
      if (skid_v) begin
        out_idx  <= skid_idx;
        out_val  <= skid_val;
        out_last <= skid_last;
      end else begin
        out_idx  <= tg[POS_Z].idx;
        out_val  <= sz;
        out_last <= tg[POS_Z].last;
      end
    end else if (move) begin
      skid_idx  <= tg[POS_Z].idx;
      skid_val  <= sz;
      skid_last <= tg[POS_Z].last;
    end
  end

  assign step.valid             = out_v;
  assign step.element_index_out = out_idx;
  assign step.step_value        = out_val;
  assign step.last_out          = out_last;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `AOU_ASSERT_IMP(a_no_accept_clearing, clearing, !grad.ready)
  `AOU_ASSERT_IMP(a_rmw_distinct, v3 && v4, slot3 != slot4)
  `AOU_ASSERT_IMP(a_skid_behind_out, skid_v, out_v)
  `AOU_ASSERT_NEXT(a_hazard_bubble, move && hazard, !v3)

endmodule

`default_nettype wire
